>>> hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared widths, codes and types of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_WIDTH = 32;

    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W     = 18;
    localparam int BSZ_CFG_W  = 17;
    localparam int BCNT_CFG_W = 7;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OFF_W      = SIZE_W + IDX_W;
    localparam int SPAN_W     = CNT_W + SIZE_W;
    localparam int DIV_CNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_link;

endpackage

>>> hw/rtl/fbpa_req_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if
// request channel of the block pool allocator
// ----------------------------------------------------------------------------
interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [ADDR_WIDTH-1:0] block_address;

    modport source (output valid, output kind, output block_address, input ready);
    modport sink   (input valid, input kind, input block_address, output ready);
endinterface

>>> hw/rtl/fbpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// response channel of the block pool allocator
// ----------------------------------------------------------------------------
interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ADDR_WIDTH-1:0] granted_address;
    logic [CNT_W-1:0]      blocks_in_use;

    modport source (output valid, output status, output granted_address,
                    output blocks_in_use, input ready);
    modport sink   (input valid, input status, input granted_address,
                    input blocks_in_use, output ready);
endinterface

>>> hw/rtl/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider, one quotient bit per cycle, maps an offset to a block
// ----------------------------------------------------------------------------
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OFF_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [OFF_W-1:0]     r_rem;
    logic [OFF_W-1:0]     r_dsh;
    logic [IDX_W-1:0]     r_quot;
    logic [OFF_W:0]       trial;

    assign trial = {1'b0, r_rem} - {1'b0, r_dsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(IDX_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= OFF_W'(i_divisor) << (IDX_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (!trial[OFF_W]) begin
                r_rem <= trial[OFF_W-1:0];
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= IDX_W'({r_quot, ~trial[OFF_W]});
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hw/rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top: allocate passes through ST_ALLOC, free waits
// in ST_FREE for the bit-serial divider, reset/nop go straight to ST_RESP.
// one request at a time; link memory has registered reads.
// sync reset and any write to base, size or count relink the pool at once via
// per-entry valid bits, no clearing pass
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fbpa_req_if.sink             i_req,
    fbpa_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_FREE  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    // config
    logic [ADDR_WIDTH-1:0] r_cfg_base;
    logic [BSZ_CFG_W-1:0]  r_cfg_size;
    logic [BCNT_CFG_W-1:0] r_cfg_cnt;

    logic [ADDR_WIDTH-1:0] used_base;
    logic [SIZE_W-1:0]     used_size;
    logic [SIZE_W-1:0]     size_rnd;
    logic [CNT_W-1:0]      used_n;

    // control
    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_head, n_head;
    logic                  r_head_vld, n_head_vld;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [MAX_BLOCKS-1:0] r_vld, n_vld;
    logic                  r_rsp_valid, n_rsp_valid;

    // payload
    logic [STATUS_W-1:0]   r_p_status, n_p_status;
    logic [ADDR_WIDTH-1:0] r_p_addr, n_p_addr;
    logic [STATUS_W-1:0]   r_rsp_status;
    logic [ADDR_WIDTH-1:0] r_rsp_addr;
    logic [CNT_W-1:0]      r_rsp_count;
    logic                  rsp_load;

    logic [IDX_W+SIZE_W-1:0] r_prod;
    logic [SPAN_W-1:0]       span;

    // link memory
    t_link                 r_mem [MAX_BLOCKS];
    t_link                 r_mem_q;
    logic                  r_vld_q;
    logic                  mem_we;
    t_link                 mem_wdata;
    t_link                 link_rd;
    t_link                 link_dflt;
    logic [CNT_W-1:0]      head_nxt;

    // free path
    logic                  req_acc;
    logic                  rebuild;
    logic [ADDR_WIDTH-1:0] off;
    logic                  in_range;
    logic                  div_start;
    logic                  div_done;
    logic [IDX_W-1:0]      div_quot;

    assign size_rnd  = (SIZE_W'(r_cfg_size) + SIZE_W'(3)) & ~SIZE_W'(3);
    assign used_size = (size_rnd < SIZE_W'(4)) ? SIZE_W'(4) : size_rnd;
    assign used_base = (r_cfg_base + ADDR_WIDTH'(3)) & ~ADDR_WIDTH'(3);

    always_comb begin
        if (r_cfg_cnt == '0) begin
            used_n = CNT_W'(1);
        end else if (32'(r_cfg_cnt) > 32'(MAX_BLOCKS)) begin
            used_n = CNT_W'(MAX_BLOCKS);
        end else begin
            used_n = CNT_W'(r_cfg_cnt);
        end
    end

    assign span = SPAN_W'(used_n) * SPAN_W'(used_size);

    always_ff @(posedge i_clk) begin
        r_prod <= (IDX_W+SIZE_W)'(r_head) * (IDX_W+SIZE_W)'(used_size);
    end

    // untouched entries read as the in-order link
    assign head_nxt       = CNT_W'(r_head) + CNT_W'(1);
    assign link_dflt.last = (head_nxt >= used_n);
    assign link_dflt.idx  = link_dflt.last ? '0 : head_nxt[IDX_W-1:0];
    assign link_rd        = r_vld_q ? r_mem_q : link_dflt;

    assign mem_wdata.last = ~r_head_vld;
    assign mem_wdata.idx  = r_head;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[div_quot] <= mem_wdata;
        end
        r_mem_q <= r_mem[r_head];
        r_vld_q <= r_vld[r_head];
    end

    assign req_acc  = i_req.valid && i_req.ready;
    assign off      = i_req.block_address - used_base;
    assign in_range = (i_req.block_address >= used_base)
                   && (64'(off) < 64'(span));
    assign rebuild  = (i_cfg_we && (i_cfg_idx == CFG_POOL_BASE
                                 || i_cfg_idx == CFG_BLOCK_SIZE
                                 || i_cfg_idx == CFG_BLOCK_COUNT))
                   || (req_acc && i_req.kind == KIND_RESET);

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (OFF_W'(off)),
        .i_divisor  (used_size),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_head_vld  = r_head_vld;
        n_count     = r_count;
        n_vld       = r_vld;
        n_p_status  = r_p_status;
        n_p_addr    = r_p_addr;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        rsp_load    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_p_status = STAT_OK;
                    n_p_addr   = '0;
                    n_state    = ST_RESP;
                    unique case (i_req.kind)
                        KIND_ALLOC: begin
                            if (r_head_vld) begin
                                n_state = ST_ALLOC;
                            end else begin
                                n_p_status = STAT_EMPTY;
                            end
                        end
                        KIND_FREE: begin
                            if (in_range) begin
                                div_start = 1'b1;
                                n_state   = ST_FREE;
                            end else begin
                                n_p_status = STAT_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                n_head     = link_rd.idx;
                n_head_vld = ~link_rd.last;
                n_p_addr   = used_base + ADDR_WIDTH'(r_prod);
                if (r_count < used_n) begin
                    n_count = r_count + 1'b1;
                end
                n_state = ST_RESP;
            end
            ST_FREE: begin
                if (div_done) begin
                    mem_we           = 1'b1;
                    n_vld[div_quot]  = 1'b1;
                    n_head           = div_quot;
                    n_head_vld       = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    rsp_load    = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (rebuild) begin
            n_vld      = '0;
            n_head     = '0;
            n_head_vld = 1'b1;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_head_vld  <= 1'b1;
            r_count     <= '0;
            r_vld       <= '0;
            r_rsp_valid <= 1'b0;
            r_cfg_base  <= '0;
            r_cfg_size  <= BSZ_CFG_W'(4);
            r_cfg_cnt   <= BCNT_CFG_W'(MAX_BLOCKS);
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_head_vld  <= n_head_vld;
            r_count     <= n_count;
            r_vld       <= n_vld;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POOL_BASE:   r_cfg_base <= ADDR_WIDTH'(i_cfg_wdata);
                    CFG_BLOCK_SIZE:  r_cfg_size <= i_cfg_wdata[BSZ_CFG_W-1:0];
                    CFG_BLOCK_COUNT: r_cfg_cnt  <= i_cfg_wdata[BCNT_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_status <= n_p_status;
        r_p_addr   <= n_p_addr;
        if (rsp_load) begin
            r_rsp_status <= r_p_status;
            r_rsp_addr   <= r_p_addr;
            r_rsp_count  <= r_count;
        end
    end

    assign i_req.ready           = (r_state == ST_IDLE);
    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.status          = r_rsp_status;
    assign o_rsp.granted_address = r_rsp_addr;
    assign o_rsp.blocks_in_use   = r_rsp_count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= used_n)
        else $error("in-use count above block count");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_FREE)
        else $error("divider finished outside free");

    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FREE && div_done) |=> r_head_vld)
        else $error("free list head not valid after free");

    a_pool_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.kind == KIND_RESET)
        |=> (r_count == '0 && r_head == '0 && r_head_vld && r_vld == '0))
        else $error("pool reset request did not relink pool");

endmodule
